// File: src/rgb_to_hsl_converter_assert.svh
// Assertion macros for the RGB to HSL converter.
// Needs nothing else; the including module supplies clock, reset and signals.
`ifndef RGB_TO_HSL_CONVERTER_ASSERT_SVH
`define RGB_TO_HSL_CONVERTER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define RTHC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define RTHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rthc_pkg.sv
// Shared constants, types and the front-to-divider bundle of the RGB to HSL converter.
// Used by rthc_prep, rthc_divider and rgb_to_hsl_converter; depends on nothing.
package rthc_pkg;

  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int SUM_W  = CH_W + 1;
  localparam int DIFF_W = CH_W + 3;
  localparam int HUE_W  = 9;
  localparam int PCT_W  = 7;

  localparam logic [CH_W-1:0]  CH_MAX    = 8'd255;
  localparam logic [HUE_W-1:0] FULL_TURN = 9'd360;
  localparam int               HUE_SCALE = 60;
  localparam int               PCT_SCALE = 100;

  // lightness = floor(sum * 100 / 510) = (sum * LIGHT_RECIP) >> LIGHT_SHIFT, exact for sum <= 510
  localparam int LIGHT_SHIFT = 20;
  localparam int LIGHT_RECIP = 205610;
  localparam int LIGHT_RW    = 18;
  localparam int LIGHT_PW    = SUM_W + LIGHT_RW;

  // Divider geometry: quotient bits cover the hue range, divisor is one channel wide
  localparam int DIV_QUO_W = HUE_W;
  localparam int DIV_DEN_W = CH_W;
  localparam int DIV_NUM_W = DIV_QUO_W + DIV_DEN_W;
  localparam int DIV_STEPS = 3;

  localparam int PREP_STAGES = 3;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic                 valid;
    logic                 grey;
    logic                 neg;
    logic [PCT_W-1:0]     light;
    logic [DIV_NUM_W-1:0] hue_num;
    logic [DIV_DEN_W-1:0] hue_den;
    logic [DIV_NUM_W-1:0] sat_num;
    logic [DIV_DEN_W-1:0] sat_den;
  } prep_t;

endpackage

// File: src/rthc_prep.sv
// Front end of the converter: unpack, extrema and sector, then divider operands.
// Three register stages; depends on rthc_pkg.
module rthc_prep (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [rthc_pkg::PIX_W-1:0] pixel_rgb,
  output rthc_pkg::prep_t            prep
);

  localparam int CH_W   = rthc_pkg::CH_W;
  localparam int SUM_W  = rthc_pkg::SUM_W;
  localparam int DIFF_W = rthc_pkg::DIFF_W;
  localparam int NUM_W  = rthc_pkg::DIV_NUM_W;

  // Stage 1: channels, max, min, winning sector
  logic                v1;
  logic [CH_W-1:0]     r1, g1, b1, mx1, mn1;
  rthc_pkg::sector_t   sec1;

  logic [CH_W-1:0]     r0, g0, b0, mx0, mn0;
  rthc_pkg::sector_t   sec0;

  always_comb begin
    r0 = pixel_rgb[3*CH_W-1:2*CH_W];
    g0 = pixel_rgb[2*CH_W-1:CH_W];
    b0 = pixel_rgb[CH_W-1:0];
    // red wins ties, then green
    if (r0 >= g0 && r0 >= b0) begin
      sec0 = rthc_pkg::SEC_RED;
      mx0  = r0;
    end else if (g0 >= b0) begin
      sec0 = rthc_pkg::SEC_GREEN;
      mx0  = g0;
    end else begin
      sec0 = rthc_pkg::SEC_BLUE;
      mx0  = b0;
    end
    if (r0 <= g0 && r0 <= b0) begin
      mn0 = r0;
    end else if (g0 <= b0) begin
      mn0 = g0;
    end else begin
      mn0 = b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    r1   <= r0;
    g1   <= g0;
    b1   <= b0;
    mx1  <= mx0;
    mn1  <= mn0;
    sec1 <= sec0;
  end

  // Stage 2: chroma, sum, saturation divisor, hue difference
  logic              v2, grey2, neg2;
  logic [CH_W-1:0]   c2, den2;
  logic [SUM_W-1:0]  sum2;
  logic [DIFF_W-1:0] diff2;

  logic [CH_W-1:0]   c_next, den_next;
  logic [SUM_W-1:0]  sum_next, dist_next;
  logic [DIFF_W-1:0] diff_next;
  logic              neg_next;

  always_comb begin
    c_next   = mx1 - mn1;
    sum_next = SUM_W'(mx1) + SUM_W'(mn1);
    if (sum_next >= SUM_W'(rthc_pkg::CH_MAX)) begin
      dist_next = sum_next - SUM_W'(rthc_pkg::CH_MAX);
    end else begin
      dist_next = SUM_W'(rthc_pkg::CH_MAX) - sum_next;
    end
    den_next  = CH_W'(SUM_W'(rthc_pkg::CH_MAX) - dist_next);
    neg_next  = 1'b0;
    diff_next = '0;
    case (sec1)
      rthc_pkg::SEC_RED: begin
        neg_next = b1 > g1;
        if (b1 > g1) begin
          diff_next = DIFF_W'(b1 - g1);
        end else begin
          diff_next = DIFF_W'(g1 - b1);
        end
      end
      rthc_pkg::SEC_GREEN: begin
        diff_next = (DIFF_W'(c_next) << 1) + DIFF_W'(b1) - DIFF_W'(r1);
      end
      rthc_pkg::SEC_BLUE: begin
        diff_next = (DIFF_W'(c_next) << 2) + DIFF_W'(r1) - DIFF_W'(g1);
      end
      default: begin
        diff_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    c2    <= c_next;
    den2  <= den_next;
    sum2  <= sum_next;
    diff2 <= diff_next;
    neg2  <= neg_next;
    grey2 <= (c_next == '0);
  end

  // Stage 3: scale the numerators, lightness by reciprocal multiply
  logic                              v3, grey3, neg3;
  logic [rthc_pkg::PCT_W-1:0]        light3;
  logic [NUM_W-1:0]                  hue_num3, sat_num3;
  logic [CH_W-1:0]                   hue_den3, sat_den3;
  logic [rthc_pkg::LIGHT_PW-1:0]     light_prod;

  assign light_prod = rthc_pkg::LIGHT_PW'(sum2)
                    * rthc_pkg::LIGHT_PW'(rthc_pkg::LIGHT_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    grey3    <= grey2;
    neg3     <= neg2;
    light3   <= light_prod[rthc_pkg::LIGHT_SHIFT +: rthc_pkg::PCT_W];
    hue_num3 <= NUM_W'(diff2) * NUM_W'(rthc_pkg::HUE_SCALE);
    sat_num3 <= NUM_W'(c2) * NUM_W'(rthc_pkg::PCT_SCALE);
    hue_den3 <= c2;
    sat_den3 <= den2;
  end

  assign prep.valid   = v3;
  assign prep.grey    = grey3;
  assign prep.neg     = neg3;
  assign prep.light   = light3;
  assign prep.hue_num = hue_num3;
  assign prep.hue_den = hue_den3;
  assign prep.sat_num = sat_num3;
  assign prep.sat_den = sat_den3;

endmodule

// File: src/rthc_divider.sv
// Pipelined restoring divider: STEPS quotient bits per register stage.
// Needs num < den * 2**QUO_W; depends on rthc_pkg for defaults.
module rthc_divider #(
  parameter int QUO_W = rthc_pkg::DIV_QUO_W,
  parameter int DEN_W = rthc_pkg::DIV_DEN_W,
  parameter int STEPS = rthc_pkg::DIV_STEPS
) (
  input  logic                   clk,
  input  logic [QUO_W+DEN_W-1:0] num,
  input  logic [DEN_W-1:0]       den,
  output logic [QUO_W-1:0]       quo
);

  localparam int NUM_W  = QUO_W + DEN_W;
  localparam int STAGES = (QUO_W + STEPS - 1) / STEPS;
  localparam int PIPE_N = STAGES - 1;

  logic [DEN_W-1:0] rem_q [PIPE_N];
  logic [QUO_W-1:0] quo_q [PIPE_N];
  logic [NUM_W-1:0] num_q [PIPE_N];
  logic [DEN_W-1:0] den_q [PIPE_N];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [DEN_W-1:0] rem_in, den_in;
    logic [QUO_W-1:0] quo_in;
    logic [NUM_W-1:0] num_in;
    logic [DEN_W-1:0] rem_c [STEPS+1];
    logic [QUO_W-1:0] quo_c [STEPS+1];

    if (s == 0) begin : g_first
      assign rem_in = num[NUM_W-1:QUO_W];
      assign quo_in = '0;
      assign num_in = num;
      assign den_in = den;
    end else begin : g_mid
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign num_in = num_q[s-1];
      assign den_in = den_q[s-1];
    end

    assign rem_c[0] = rem_in;
    assign quo_c[0] = quo_in;

    for (genvar j = 0; j < STEPS; j++) begin : g_step
      localparam int K = QUO_W - 1 - (s * STEPS + j);
      if (K >= 0) begin : g_bit
        logic [DEN_W:0] trial;
        logic           take;
        // shift in the next numerator bit, subtract when it fits
        assign trial      = {rem_c[j], num_in[K]};
        assign take       = trial >= {1'b0, den_in};
        assign rem_c[j+1] = take ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        assign quo_c[j+1] = quo_c[j] | (QUO_W'(take) << K);
      end else begin : g_pass
        assign rem_c[j+1] = rem_c[j];
        assign quo_c[j+1] = quo_c[j];
      end
    end

    if (s < PIPE_N) begin : g_reg
      always_ff @(posedge clk) begin
        rem_q[s] <= rem_c[STEPS];
        quo_q[s] <= quo_c[STEPS];
        num_q[s] <= num_in;
        den_q[s] <= den_in;
      end
    end else begin : g_out
      always_ff @(posedge clk) begin
        quo <= quo_c[STEPS];
      end
    end
  end

endmodule

// File: src/rgb_to_hsl_converter.sv
// Top level of the RGB to HSL converter: front end, two pipelined dividers, output stage.
// Depends on rthc_pkg, rthc_prep, rthc_divider and rgb_to_hsl_converter_assert.svh.
//
//   channel   signals                                   direction  handshake
//   ------    ----------------------------------------  ---------  ----------------------
//   pixel     start, busy, pixel_rgb                    in         start && !busy
//   result    done, hue_degrees, saturation_pct,        out        done, one cycle, no hold
//             lightness_pct
//
// A new transaction may be started every cycle; busy is high only during reset.
// A result passes three front-end stages, the divider stages (default 3 quotient
// bits per stage) and one output register.
// The divider stages set the depth; each resolves DIV_STEPS quotient bits.
// Reset (rst, synchronous) drops every transaction in flight.
// The receiver cannot stall, so the pipeline never holds.
`include "rgb_to_hsl_converter_assert.svh"

module rgb_to_hsl_converter #(
  parameter int DIV_STEPS = rthc_pkg::DIV_STEPS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [rthc_pkg::PIX_W-1:0] pixel_rgb,
  output logic                       done,
  output logic [rthc_pkg::HUE_W-1:0] hue_degrees,
  output logic [rthc_pkg::PCT_W-1:0] saturation_pct,
  output logic [rthc_pkg::PCT_W-1:0] lightness_pct
);

  localparam int HUE_W      = rthc_pkg::HUE_W;
  localparam int PCT_W      = rthc_pkg::PCT_W;
  localparam int QUO_W      = rthc_pkg::DIV_QUO_W;
  localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int LATENCY    = rthc_pkg::PREP_STAGES + DIV_STAGES + 1;

  logic            accept;
  rthc_pkg::prep_t prep;
  logic [QUO_W-1:0] hue_quo, sat_quo;

  // Refuse transactions only while reset clears the valid bits.
  assign busy   = rst;
  assign accept = start && !busy;

  rthc_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .pixel_rgb (pixel_rgb),
    .prep      (prep)
  );

  // Hue: 60 * difference / chroma
  rthc_divider #(
    .QUO_W (QUO_W),
    .DEN_W (rthc_pkg::DIV_DEN_W),
    .STEPS (DIV_STEPS)
  ) u_hue_div (
    .clk (clk),
    .num (prep.hue_num),
    .den (prep.hue_den),
    .quo (hue_quo)
  );

  // Saturation: 100 * chroma / (255 - |sum - 255|); same latency as the hue divider
  rthc_divider #(
    .QUO_W (QUO_W),
    .DEN_W (rthc_pkg::DIV_DEN_W),
    .STEPS (DIV_STEPS)
  ) u_sat_div (
    .clk (clk),
    .num (prep.sat_num),
    .den (prep.sat_den),
    .quo (sat_quo)
  );

  // Carry valid and the side fields alongside the divider stages.
  logic             valid_q [DIV_STAGES];
  logic             grey_q  [DIV_STAGES];
  logic             neg_q   [DIV_STAGES];
  logic [PCT_W-1:0] light_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_side
    if (s == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (rst) begin
          valid_q[s] <= 1'b0;
        end else begin
          valid_q[s] <= prep.valid;
        end
      end
      always_ff @(posedge clk) begin
        grey_q[s]  <= prep.grey;
        neg_q[s]   <= prep.neg;
        light_q[s] <= prep.light;
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (rst) begin
          valid_q[s] <= 1'b0;
        end else begin
          valid_q[s] <= valid_q[s-1];
        end
      end
      always_ff @(posedge clk) begin
        grey_q[s]  <= grey_q[s-1];
        neg_q[s]   <= neg_q[s-1];
        light_q[s] <= light_q[s-1];
      end
    end
  end

  // Output stage: fold negative red-sector hues into range, zero hue and
  // saturation for grey pixels.
  logic [HUE_W-1:0] hue_next;
  logic [PCT_W-1:0] sat_next;

  always_comb begin
    if (grey_q[DIV_STAGES-1]) begin
      hue_next = '0;
      sat_next = '0;
    end else begin
      sat_next = sat_quo[PCT_W-1:0];
      if (neg_q[DIV_STAGES-1] && hue_quo != '0) begin
        hue_next = rthc_pkg::FULL_TURN - HUE_W'(hue_quo);
      end else begin
        hue_next = HUE_W'(hue_quo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    hue_degrees    <= hue_next;
    saturation_pct <= sat_next;
    lightness_pct  <= light_q[DIV_STAGES-1];
  end

  // Every accepted transaction later produces its done strobe.
  `RTHC_ASSERT_IMPL(a_latency, clk, rst, accept, ##LATENCY done, "result strobe missing after accept")
  // No result without a matching earlier accepted transaction.
  `RTHC_ASSERT_IMPL(a_no_phantom, clk, rst, done, $past(accept, LATENCY), "result strobe without accept")
  // Results stay within their ranges.
  `RTHC_ASSERT_IMPL(a_range, clk, rst, done, hue_degrees < rthc_pkg::FULL_TURN && saturation_pct <= PCT_W'(rthc_pkg::PCT_SCALE) && lightness_pct <= PCT_W'(rthc_pkg::PCT_SCALE), "result out of range")

endmodule

// File: tb/tb_rgb_to_hsl_converter.sv
// Self-checking testbench for rgb_to_hsl_converter: drives pixels through the start/busy
// handshake and checks every done strobe against an integer HSL predictor.
// Depends on rthc_pkg and the rgb_to_hsl_converter RTL.
module tb_rgb_to_hsl_converter;

  localparam int PIX_W     = rthc_pkg::PIX_W;
  localparam int HUE_W     = rthc_pkg::HUE_W;
  localparam int PCT_W     = rthc_pkg::PCT_W;
  localparam int HUE_SCALE = rthc_pkg::HUE_SCALE;
  localparam int PCT_SCALE = rthc_pkg::PCT_SCALE;

  // One expected conversion result, at the widths of the result ports.
  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] light;
  } hsl_t;

  // Hold the predicted HSL values of accepted pixels, oldest first, and
  // compare each done strobe against the head of the queue.
  class hsl_scoreboard;
    hsl_t expected_q[$];
    int   mismatches;
    int   pixels_in;
    int   results_out;

    // Integer-exact HSL: all three fields truncate toward zero.
    function hsl_t predict_hsl(logic [PIX_W-1:0] px);
      int                r, g, b, mx, mn, chroma, sum, offset, mag;
      rthc_pkg::sector_t sec;
      hsl_t              res;
      r = px[23:16];
      g = px[15:8];
      b = px[7:0];
      // Red wins ties for the maximum, then green.
      sec = rthc_pkg::SEC_RED;
      mx  = r;
      if (g > mx) begin
        sec = rthc_pkg::SEC_GREEN;
        mx  = g;
      end
      if (b > mx) begin
        sec = rthc_pkg::SEC_BLUE;
        mx  = b;
      end
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      chroma    = mx - mn;
      sum       = mx + mn;
      res.light = PCT_W'((PCT_SCALE * sum) / 510);
      res.hue   = '0;
      res.sat   = '0;
      // A grey pixel keeps hue and saturation at zero.
      if (chroma != 0) begin
        offset  = (sum >= 255) ? sum - 255 : 255 - sum;
        res.sat = PCT_W'((PCT_SCALE * chroma) / (255 - offset));
        case (sec)
          rthc_pkg::SEC_RED: begin
            if (g >= b) begin
              res.hue = HUE_W'((HUE_SCALE * (g - b)) / chroma);
            end else begin
              // Truncate the magnitude first; a zero magnitude stays at zero.
              mag     = (HUE_SCALE * (b - g)) / chroma;
              res.hue = (mag == 0) ? '0 : HUE_W'(360 - mag);
            end
          end
          rthc_pkg::SEC_GREEN: begin
            res.hue = HUE_W'((HUE_SCALE * (2 * chroma + b - r)) / chroma);
          end
          default: begin
            res.hue = HUE_W'((HUE_SCALE * (4 * chroma + r - g)) / chroma);
          end
        endcase
      end
      return res;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px);
      expected_q.push_back(predict_hsl(px));
      pixels_in++;
    endfunction

    function void check_result(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
                               logic [PCT_W-1:0] light);
      hsl_t exp_res;
      results_out++;
      if (expected_q.size() == 0) begin
        $error("result with no pixel pending: hue %0d sat %0d light %0d", hue, sat, light);
        mismatches++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (hue !== exp_res.hue) begin
        $error("hue_degrees: expected %0d, got %0d", exp_res.hue, hue);
        mismatches++;
      end
      if (sat !== exp_res.sat) begin
        $error("saturation_pct: expected %0d, got %0d", exp_res.sat, sat);
        mismatches++;
      end
      if (light !== exp_res.light) begin
        $error("lightness_pct: expected %0d, got %0d", exp_res.light, light);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [PIX_W-1:0] pixel_rgb;
  logic             done;
  logic [HUE_W-1:0] hue_degrees;
  logic [PCT_W-1:0] saturation_pct;
  logic [PCT_W-1:0] lightness_pct;

  hsl_scoreboard sb;
  int            idle_max;   // longest idle gap before a pixel in the current phase

  rgb_to_hsl_converter DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .pixel_rgb      (pixel_rgb),
    .done           (done),
    .hue_degrees    (hue_degrees),
    .saturation_pct (saturation_pct),
    .lightness_pct  (lightness_pct)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample results at the edge that ends the strobe cycle; the DUT updates
  // its outputs with nonblocking assignments, so these are pre-edge values.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(hue_degrees, saturation_pct, lightness_pct);
  end

  // Drive one pixel transaction. Idle for a random gap first, then hold start
  // high until an edge sees busy low. Each branch makes exactly one
  // assignment to start per edge, so back-to-back pixels keep start high.
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int gap;
    gap = $urandom_range(0, idle_max);
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    pixel_rgb <= px;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_pixel(px);
  endtask

  // Draw a pixel with a bias toward the interesting corners: ties between
  // two channels, near-grey colors, saturated channels, and plain random noise.
  function automatic logic [PIX_W-1:0] make_pixel();
    logic [7:0] r, g, b, base;
    base = 8'($urandom);
    r    = 8'($urandom);
    g    = 8'($urandom);
    b    = 8'($urandom);
    case ($urandom_range(0, 5))
      0: begin
        // Near-grey: channels within a few counts of one another.
        r = 8'(base + $urandom_range(0, 3));
        g = 8'(base + $urandom_range(0, 3));
        b = 8'(base + $urandom_range(0, 3));
      end
      1: begin
        // Two channels tie; pick which pair.
        case ($urandom_range(0, 2))
          0: g = r;
          1: b = r;
          default: b = g;
        endcase
      end
      2: begin
        // Pin channels at the rails.
        if ($urandom_range(0, 1)) r = $urandom_range(0, 1) ? 8'hff : 8'h00;
        if ($urandom_range(0, 1)) g = $urandom_range(0, 1) ? 8'hff : 8'h00;
        if ($urandom_range(0, 1)) b = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
      3: begin
        // Max and min close together, near dark or near bright.
        base = $urandom_range(0, 1) ? 8'($urandom_range(250, 255)) : 8'($urandom_range(0, 5));
        r    = base;
        g    = 8'(base ^ $urandom_range(0, 1));
        b    = 8'(base ^ $urandom_range(0, 3));
      end
      default: ;
    endcase
    return {r, g, b};
  endfunction

  initial begin
    logic [PIX_W-1:0] directed_px[$];
    int               guard;

    sb        = new();
    rst       = 1'b1;
    start     = 1'b0;
    pixel_rgb = '0;
    idle_max  = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed corners: black, white, primaries, grey, ties for the maximum,
    // a red hue whose negative part truncates to zero, the hue just below a
    // full turn, the smallest and largest saturation divisors, and each
    // sector with its secondary channel ordering flipped.
    directed_px = '{24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff,
                    24'h808080, 24'hffff00, 24'hff00ff, 24'h00ffff, 24'hff0001,
                    24'hff0100, 24'hff0005, 24'h000001, 24'hfffeff, 24'h010000,
                    24'h10f020, 24'h20f010, 24'h1020f0, 24'h2010f0, 24'h7f8081,
                    24'hfe0000, 24'h0100ff};
    foreach (directed_px[i]) send_pixel(directed_px[i]);

    // Random phases, alternating back-to-back streams with idle gaps.
    for (int phase = 0; phase < 6; phase++) begin
      idle_max = (phase % 2 == 0) ? 0 : 6;
      repeat (150) send_pixel(make_pixel());
    end
    start <= 1'b0;

    // Drain the pipeline, then linger past the latency to catch stray strobes.
    guard = 0;
    while (sb.expected_q.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (12) @(posedge clk);

    if (sb.expected_q.size() != 0) begin
      $error("%0d pixels never produced a result", sb.expected_q.size());
      sb.mismatches++;
    end

    $display("Sent %0d pixels (directed corners plus biased random), checked %0d results.",
             sb.pixels_in, sb.results_out);
    $display("Field mismatches and missing or extra results: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("rgb_to_hsl_converter verification clean");
    end else begin
      $display("rgb_to_hsl_converter verification failed");
    end
    $finish;
  end

  // Abort a hung run well beyond the slowest legal completion time.
  initial begin
    #2000000;
    $display("rgb_to_hsl_converter verification failed");
    $finish;
  end
endmodule
